@@ hw/rtl/bm5_pkg.sv @@
`timescale 1ns / 1ps

package bm5_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 4096;

  // Field widths fixed by the register and counter definitions.
  localparam int MODE_W = 1;
  localparam int WID_W  = 10;
  localparam int HGT_W  = 13;
  localparam int ROW_W  = 12;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CMP_W  = 15;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 2;
  localparam int WIN_N  = 5;
  localparam int WIN_BITS = WIN_N * WIN_N;
  localparam int LINES  = 4;

  localparam logic [ROW_W-1:0] ROW_CAP = '1;
  localparam logic [7:0] PIX_FG = 8'd255;
  localparam logic [7:0] PIX_BG = 8'd0;

  localparam logic [WID_W-1:0]  MIN_WIDTH_VAL  = WID_W'(3);
  localparam logic [WID_W-1:0]  MAX_WIDTH_VAL  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0]  MIN_HEIGHT_VAL = HGT_W'(3);
  localparam logic [HGT_W-1:0]  MAX_HEIGHT_VAL = HGT_W'(MAX_HEIGHT);
  localparam logic [WID_W-1:0]  RST_WIDTH  = WID_W'(512);
  localparam logic [HGT_W-1:0]  RST_HEIGHT = HGT_W'(512);

  localparam logic [IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic MODE_ERODE  = 1'b0;
  localparam logic MODE_DILATE = 1'b1;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] in_pixel;
  } bm5_in_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       out_last;
  } bm5_out_t;

  // Everything the second stage needs to know about one item.
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [1:0]       rsel;
    logic             fg;
    logic             emit;
    logic             last;
    logic [WIN_N-1:0] row_ok;
    logic [WIN_N-1:0] col_ok;
  } bm5_stage_t;

  function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r);
    return (r == ROW_CAP) ? ROW_CAP : r + ROW_W'(1);
  endfunction

  // Window bit s*5+k holds column offset s-2 and row offset k-2.
  function automatic logic decide(input logic [WIN_BITS-1:0] win,
                                  input logic mode,
                                  input logic [WIN_N-1:0] row_ok,
                                  input logic [WIN_N-1:0] col_ok);
    logic all_fg;
    logic any_fg;
    logic b;
    int   dr;
    int   dc;
    all_fg = 1'b1;
    any_fg = 1'b0;
    for (int s = 0; s < WIN_N; s++) begin
      for (int k = 0; k < WIN_N; k++) begin
        dr = (k >= 2) ? k - 2 : 2 - k;
        dc = (s >= 2) ? s - 2 : 2 - s;
        b  = win[s*WIN_N+k] & row_ok[k] & col_ok[s];
        if ((dr + dc <= 2) && !b) all_fg = 1'b0;
        if (!((dr == 2) && (dc == 2)) && b) any_fg = 1'b1;
      end
    end
    return (mode == MODE_DILATE) ? any_fg : all_fg;
  endfunction

endpackage

@@ hw/rtl/bm5_ram.sv @@
`timescale 1ns / 1ps

module bm5_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/bm5_ctrl.sv @@
`timescale 1ns / 1ps

module bm5_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        fire_i,
  input  bm5_pkg::bm5_in_t            in_data_i,
  input  logic [bm5_pkg::WID_W-1:0]   image_width_i,
  input  logic [bm5_pkg::HGT_W-1:0]   image_height_i,
  output logic [bm5_pkg::COL_W-1:0]   rd_addr_o,
  output logic                        stage_valid_o,
  output bm5_pkg::bm5_stage_t         stage_o
);
  import bm5_pkg::*;

  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             stage_valid_q, stage_valid_d;
  bm5_stage_t       stage_q, stage_d;

  logic [WID_W-1:0] w;
  logic [HGT_W-1:0] h;
  logic [COL_W-1:0] c_pre, oc_pre;
  logic [ROW_W-1:0] r_pre, or_pre;
  logic [CMP_W-1:0] c_inc, oc_inc, rsum, csum;
  logic             emit, last;

  always_comb begin
    w = image_width_i;
    if (w < MIN_WIDTH_VAL) w = MIN_WIDTH_VAL;
    if (w > MAX_WIDTH_VAL) w = MAX_WIDTH_VAL;
    h = image_height_i;
    if (h < MIN_HEIGHT_VAL) h = MIN_HEIGHT_VAL;
    if (h > MAX_HEIGHT_VAL) h = MAX_HEIGHT_VAL;
  end

  always_comb begin
    // A counter left at or past the row end wraps before use.
    if (CMP_W'(in_col_q) >= CMP_W'(w)) begin
      c_pre = '0;
      r_pre = next_row(in_row_q);
    end else begin
      c_pre = in_col_q;
      r_pre = in_row_q;
    end
    if (CMP_W'(out_col_q) >= CMP_W'(w)) begin
      oc_pre = '0;
      or_pre = next_row(out_row_q);
    end else begin
      oc_pre = out_col_q;
      or_pre = out_row_q;
    end

    emit = (r_pre > ROW_W'(2)) || ((r_pre == ROW_W'(2)) && (c_pre >= COL_W'(2)));
    last = (CMP_W'(or_pre) + CMP_W'(1) >= CMP_W'(h)) &&
           (CMP_W'(oc_pre) + CMP_W'(1) >= CMP_W'(w));

    c_inc = CMP_W'(c_pre) + CMP_W'(1);
    if (c_inc >= CMP_W'(w)) begin
      in_col_d = '0;
      in_row_d = next_row(r_pre);
    end else begin
      in_col_d = c_inc[COL_W-1:0];
      in_row_d = r_pre;
    end

    oc_inc    = CMP_W'(oc_pre) + CMP_W'(1);
    out_col_d = oc_pre;
    out_row_d = or_pre;
    if (emit) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else if (oc_inc >= CMP_W'(w)) begin
        out_col_d = '0;
        out_row_d = next_row(or_pre);
      end else begin
        out_col_d = oc_inc[COL_W-1:0];
      end
    end

    stage_d.col  = c_pre;
    stage_d.rsel = r_pre[1:0];
    stage_d.fg   = (CMP_W'(r_pre) < CMP_W'(h)) && (in_data_i.action == ACT_PIXEL) &&
                   (in_data_i.in_pixel != 8'd0);
    stage_d.emit = emit;
    stage_d.last = last;
    for (int k = 0; k < WIN_N; k++) begin
      rsum = CMP_W'(or_pre) + CMP_W'(k);
      csum = CMP_W'(oc_pre) + CMP_W'(k);
      stage_d.row_ok[k] = (rsum >= CMP_W'(2)) && (rsum < CMP_W'(h) + CMP_W'(2));
      stage_d.col_ok[k] = (csum >= CMP_W'(2)) && (csum < CMP_W'(w) + CMP_W'(2));
    end

    if (accept_i) begin
      stage_valid_d = 1'b1;
    end else if (fire_i) begin
      stage_valid_d = 1'b0;
    end else begin
      stage_valid_d = stage_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q      <= '0;
      in_row_q      <= '0;
      out_col_q     <= '0;
      out_row_q     <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      if (accept_i) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      stage_q <= stage_d;
    end
  end

  assign rd_addr_o     = c_pre;
  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;

endmodule

@@ hw/rtl/bm5_filter.sv @@
`timescale 1ns / 1ps

module bm5_filter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  logic                         out_ready_i,
  input  logic                         mode_i,
  input  bm5_pkg::bm5_stage_t          stage_i,
  input  logic [bm5_pkg::LINES-1:0]    rd_data_i,
  output logic [bm5_pkg::LINES-1:0]    wr_data_o,
  output logic                         out_valid_o,
  output bm5_pkg::bm5_out_t            out_data_o
);
  import bm5_pkg::*;

  logic [WIN_BITS-1:0] win_q, win_d;
  logic [WIN_N-1:0]    newcol;
  logic                out_valid_q, out_valid_d;
  bm5_out_t            out_q, out_d;

  always_comb begin
    // Line slot (rsel + k) mod 4 holds the row 4-k rows above, so the oldest comes first.
    for (int k = 0; k < LINES; k++) begin
      newcol[k] = rd_data_i[2'(32'(stage_i.rsel) + k)];
    end
    newcol[LINES] = stage_i.fg;

    wr_data_o = rd_data_i;
    wr_data_o[stage_i.rsel] = stage_i.fg;

    win_d = {newcol, win_q[WIN_BITS-1:WIN_N]};

    out_d.out_pixel = decide(win_d, mode_i, stage_i.row_ok, stage_i.col_ok) ? PIX_FG : PIX_BG;
    out_d.out_last  = stage_i.last;

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = fire_i && stage_i.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire_i) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && stage_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hw/rtl/binary_morphology_5x5_core.sv @@
`timescale 1ns / 1ps
// A result passes the stage and output registers; the line store is read once and
// written once per item. Throughput: one item per cycle unless the output stalls.
// A frame of W*H pixels needs 2*W+2 trailing flush items to drain its last two rows.
// Reset clears counters, window and valid flags; the line store is left as is and
// needs no clearing pass, since unwritten cells fall outside the image and are masked.
module binary_morphology_5x5_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bm5_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [bm5_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  bm5_pkg::bm5_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output bm5_pkg::bm5_out_t         out_data_o
);
  import bm5_pkg::*;

  logic             mode_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;

  logic             accept, fire, out_ready, stage_valid;
  bm5_stage_t       stage;
  logic [COL_W-1:0] rd_addr;
  logic [LINES-1:0] rd_data, wr_data, ram_rdata, fwd_data_q;
  logic             fwd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_ERODE;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i[WID_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_o || !out_stall_i;
  assign fire       = stage_valid && out_ready;
  assign in_stall_o = stage_valid && !out_ready;
  assign accept     = in_valid_i && !in_stall_o;

  bm5_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .fire_i         (fire),
    .in_data_i      (in_data_i),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .rd_addr_o      (rd_addr),
    .stage_valid_o  (stage_valid),
    .stage_o        (stage)
  );

  // One word per column holds that column's bit of the four most recent rows.
  bm5_ram #(
    .WIDTH (LINES),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (stage.col),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // An item that reads the column being written in the same cycle takes the new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= fire && (stage.col == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
    end
  end

  assign rd_data = fwd_q ? fwd_data_q : ram_rdata;

  bm5_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .out_ready_i (out_ready),
    .mode_i      (mode_q),
    .stage_i     (stage),
    .rd_data_i   (rd_data),
    .wr_data_o   (wr_data),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ bench/tb_binary_morphology_5x5_core.sv @@
`timescale 1ns / 1ps

module tb_binary_morphology_5x5_core;
  import bm5_pkg::*;

  localparam logic [IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 380;

  class morph_scoreboard;
    bit                  row_store [LINES][MAX_WIDTH];
    logic [WIN_BITS-1:0] window = '0;
    int unsigned         in_col, in_row, out_col, out_row;
    logic                mode_reg = MODE_ERODE;
    logic [WID_W-1:0]    width_reg = RST_WIDTH;
    logic [HGT_W-1:0]    height_reg = RST_HEIGHT;
    bm5_out_t            expected_pixels [$];
    int unsigned         items_taken, results_seen, frames_closed, fg_results;
    int unsigned         mismatches, strays, reported;

    static function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      return (v < 3) ? 3 : ((v > hi) ? hi : v);
    endfunction

    function int unsigned row_after(int unsigned r);
      return (r < ROW_CAP) ? r + 1 : ROW_CAP;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_MODE:   mode_reg = data[0];
        CFG_WIDTH:  width_reg = data[WID_W-1:0];
        CFG_HEIGHT: height_reg = data[HGT_W-1:0];
        default: ;
      endcase
    endfunction

    // Window bit s*5+k holds column offset s-2 and row offset k-2 around the output pixel.
    function logic [7:0] morph_verdict(int unsigned w, int unsigned h);
      int   rr;
      int   cc;
      int   dr;
      int   dc;
      logic lit;
      logic all_fg;
      logic any_fg;
      all_fg = 1'b1;
      any_fg = 1'b0;
      for (int s = 0; s < WIN_N; s++) begin
        for (int k = 0; k < WIN_N; k++) begin
          rr = int'(out_row) - 2 + k;
          cc = int'(out_col) - 2 + s;
          dr = (k > 2) ? k - 2 : 2 - k;
          dc = (s > 2) ? s - 2 : 2 - s;
          lit = rr >= 0 && rr < int'(h) && cc >= 0 && cc < int'(w) && window[s*WIN_N+k];
          if (dr + dc <= 2 && !lit) all_fg = 1'b0;
          if ((dr != 2 || dc != 2) && lit) any_fg = 1'b1;
        end
      end
      return (((mode_reg == MODE_DILATE) ? any_fg : all_fg) ? PIX_FG : PIX_BG);
    endfunction

    function void note_item(bm5_in_t item);
      int unsigned      w;
      int unsigned      h;
      int unsigned      c;
      int unsigned      r;
      logic [WIN_N-1:0] column;
      logic             fg;
      bm5_out_t         res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      items_taken++;
      // A size change between items can leave a counter past the new width.
      if (in_col >= w) begin
        in_col = 0;
        in_row = row_after(in_row);
      end
      if (out_col >= w) begin
        out_col = 0;
        out_row = row_after(out_row);
      end
      c = in_col;
      r = in_row;
      fg = (r < h) && (item.action == ACT_PIXEL) && (item.in_pixel != 8'd0);
      for (int k = 0; k < LINES; k++) column[k] = row_store[(r + k) % LINES][c];
      column[LINES] = fg;
      row_store[r % LINES][c] = fg;
      window = {column, window[WIN_BITS-1:WIN_N]};
      in_col = c + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row = row_after(r);
      end
      if (r > 2 || (r == 2 && c >= 2)) begin
        res.out_pixel = morph_verdict(w, h);
        res.out_last = (out_row >= h - 1) && (out_col >= w - 1);
        if (res.out_last) begin
          in_col = 0;
          in_row = 0;
          out_col = 0;
          out_row = 0;
        end else begin
          out_col++;
          if (out_col >= w) begin
            out_col = 0;
            out_row = row_after(out_row);
          end
        end
        expected_pixels.push_back(res);
      end
    endfunction

    function void check_result(bm5_out_t got);
      bm5_out_t want;
      results_seen++;
      if (got.out_last) frames_closed++;
      if (got.out_pixel == PIX_FG) fg_results++;
      if (expected_pixels.size() == 0) begin
        strays++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result pixel %0d last %0b arrived with nothing expected",
                   $realtime, got.out_pixel, got.out_last);
        end
        return;
      end
      want = expected_pixels.pop_front();
      if (got.out_pixel !== want.out_pixel || got.out_last !== want.out_last) begin
        mismatches++;
        if (reported < 10) begin
          reported++;
          $display("%0t: result %0d mismatch: pixel exp %0d got %0d, last exp %0b got %0b",
                   $realtime, results_seen, want.out_pixel, got.out_pixel,
                   want.out_last, got.out_last);
        end
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IDX_W-1:0]  cfg_index_i = CFG_MODE;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  bm5_in_t           in_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  bm5_out_t          out_data_o;

  morph_scoreboard sb = new;

  int          burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_used;
  int unsigned hold_left;
  logic [31:0] rx_cycle;

  binary_morphology_5x5_core dut (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // The receiver cycles through stall styles, with one long hold when asked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_cycle <= '0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        case (rx_cycle[10:9])
          2'd0:    out_stall_i <= 1'b0;
          2'd1:    out_stall_i <= ($urandom_range(0, 3) == 0);
          2'd2:    out_stall_i <= ($urandom_range(0, 9) < 6);
          default: out_stall_i <= (rx_cycle[2:0] < 3'd3);
        endcase
      end
    end
  end

  task automatic push(input logic act, input logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= {act, pix};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold the input back until every expected result is out, then let the pipe empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic m, input logic [CFG_W-1:0] wv,
                           input logic [CFG_W-1:0] hv);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom);
    junk[0] = m;
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_MODE;
    cfg_data_i <= junk;
    @(posedge clk_i);
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i <= wv;
    @(posedge clk_i);
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i <= hv;
    @(posedge clk_i);
    if ($urandom_range(0, 3) == 0) begin
      cfg_index_i <= CFG_NONE;
      cfg_data_i <= CFG_W'($urandom);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One frame of w*h pixels plus the flush tail; noise swaps in flushes inside the
  // frame and pixels inside the tail.
  task automatic send_frame(input int w, input int h, input int dens, input int noise,
                            input int pause_at);
    for (int i = 0; i < w * h + 2 * w + 2; i++) begin
      if (i == pause_at) settle();
      if (i < w * h) begin
        if ($urandom_range(0, 99) < noise) push(ACT_FLUSH, 8'($urandom));
        else push(ACT_PIXEL, ($urandom_range(0, 99) < dens) ?
                             8'($urandom_range(1, 255)) : 8'd0);
      end else begin
        if ($urandom_range(0, 99) < noise) push(ACT_PIXEL, 8'($urandom));
        else push(ACT_FLUSH, 8'($urandom));
      end
    end
  endtask

  initial begin
    bm5_in_t     directed [17];
    int          wv;
    int          hv;
    int          weff;
    int          heff;
    int          extra;
    int unsigned base;
    logic        m;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two lit pixels in a minimal frame, with a flush inside the frame and pixels in the tail.
    directed = '{{ACT_PIXEL, 8'd0},   {ACT_FLUSH, 8'd255}, {ACT_PIXEL, 8'd0},
                 {ACT_PIXEL, 8'd0},   {ACT_PIXEL, 8'd1},   {ACT_PIXEL, 8'd0},
                 {ACT_PIXEL, 8'd0},   {ACT_PIXEL, 8'd0},   {ACT_PIXEL, 8'd128},
                 {ACT_FLUSH, 8'd0},   {ACT_FLUSH, 8'd0},   {ACT_PIXEL, 8'd255},
                 {ACT_FLUSH, 8'd255}, {ACT_FLUSH, 8'd0},   {ACT_PIXEL, 8'd127},
                 {ACT_FLUSH, 8'd0},   {ACT_FLUSH, 8'd0}};
    configure(MODE_DILATE, 13'd3, 13'd3);
    steady = 1'b1;
    foreach (directed[i]) push(directed[i].action, directed[i].in_pixel);
    settle();
    steady = 1'b0;

    // The receiver holds off for a long stretch early in the random frames.
    hold_go <= 1'b1;

    base = sb.items_taken;
    while (sb.items_taken - base < RANDOM_ITEMS) begin
      m = $urandom_range(0, 1);
      wv = $urandom_range(0, 12);
      hv = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) wv |= $urandom_range(1, 7) << WID_W;
      weff = morph_scoreboard::clamp_dim(wv & 'h3FF, MAX_WIDTH);
      heff = morph_scoreboard::clamp_dim(hv, MAX_HEIGHT);
      configure(m, CFG_W'(wv), CFG_W'(hv));
      send_frame(weff, heff,
                 (m == MODE_DILATE) ? $urandom_range(2, 25) : $urandom_range(80, 100),
                 $urandom_range(0, 8),
                 ($urandom_range(0, 5) == 0) ? $urandom_range(1, weff * heff) : -1);
      // Sometimes run past the frame end so that the next size change lands mid-frame.
      if ($urandom_range(0, 4) == 0) begin
        extra = $urandom_range(1, 12);
        repeat (extra) push(1'($urandom_range(0, 1)), 8'($urandom));
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    $display("Checked %0d items and %0d results over %0d frames, %0d results foreground.",
             sb.items_taken, sb.results_seen, sb.frames_closed, sb.fg_results);
    $display("Small frames in both modes, sizes below the minimum and mid-frame resizes.");
    if (sb.mismatches + sb.strays + sb.pending() == 0) begin
      $display("[binary_morphology_5x5_core] OK");
    end else begin
      $display("%0d mismatches, %0d unexpected results, %0d missing results.",
               sb.mismatches, sb.strays, sb.pending());
      $display("[binary_morphology_5x5_core] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d results still expected.", sb.pending());
    $display("[binary_morphology_5x5_core] ERROR");
    $finish;
  end

endmodule
